// ===== rtl/dcfr_pkg.sv =====
// Shared types, codes and reset constants for the drive command frame receiver.
`default_nettype none

package dcfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 32;

  localparam logic [ByteW-1:0] HeaderReset = 8'hAA;
  localparam logic [ByteW-1:0] EndReset    = 8'h55;
  localparam logic [TimeW-1:0] TimeoutReset = 16'd200;
  localparam logic [ByteW-1:0] RemoteReset  = 8'h01;
  localparam logic [ByteW-1:0] ModeReset    = 8'h01;
  localparam logic [TimeW-1:0] SinceMax     = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_END     = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_REMOTE  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MODE   = 3'd1,
    PH_LEFT   = 3'd2,
    PH_RIGHT  = 3'd3,
    PH_SUM    = 3'd4,
    PH_END    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_APPLIED    = 3'd1,
    ST_NOT_REMOTE = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_BAD_END    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    WARN_NONE    = 2'd0,
    WARN_APPLIED = 2'd1,
    WARN_STOP    = 2'd2
  } warn_e;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] end_byte;
    logic [TimeW-1:0] timeout_ms;
    logic [ByteW-1:0] remote_mode_code;
  } cfg_t;

  typedef struct packed {
    opcode_e          opcode;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                    timed_out;
    status_e                 frame_status;
    logic [ByteW-1:0]        control_mode;
    warn_e                   warning_level;
    logic signed [ByteW-1:0] right_cmd;
    logic signed [ByteW-1:0] left_cmd;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dcfr_parser.sv =====
// Frame parser: phase state machine, checksum, speed and mode registers.
`default_nettype none

module dcfr_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire dcfr_pkg::item_t item_i,
  input  wire dcfr_pkg::cfg_t  cfg_i,
  output dcfr_pkg::result_t    result_o
);

  import dcfr_pkg::*;

  phase_e                  phase_q, phase_d;
  logic [ByteW-1:0]        sum_q, sum_d;
  logic [ByteW-1:0]        held_l_q, held_l_d;
  logic [ByteW-1:0]        held_r_q, held_r_d;
  logic [ByteW-1:0]        mode_q, mode_d;
  logic signed [ByteW-1:0] app_l_q, app_l_d;
  logic signed [ByteW-1:0] app_r_q, app_r_d;
  warn_e                   warn_q, warn_d;
  logic [TimeW-1:0]        since_q, since_d;
  status_e                 status;
  logic                    tout;
  logic                    in_frame;
  phase_e                  ph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      sum_q    <= '0;
      held_l_q <= '0;
      held_r_q <= '0;
      mode_q   <= ModeReset;
      app_l_q  <= '0;
      app_r_q  <= '0;
      warn_q   <= WARN_NONE;
      since_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      held_l_q <= held_l_d;
      held_r_q <= held_r_d;
      mode_q   <= mode_d;
      app_l_q  <= app_l_d;
      app_r_q  <= app_r_d;
      warn_q   <= warn_d;
      since_q  <= since_d;
    end
  end

  // unused phase codes count as waiting for header
  assign in_frame = (phase_q != PH_HEADER) && (phase_q <= PH_END);

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    held_l_d = held_l_q;
    held_r_d = held_r_q;
    mode_d   = mode_q;
    app_l_d  = app_l_q;
    app_r_d  = app_r_q;
    warn_d   = warn_q;
    since_d  = since_q;
    status   = ST_NONE;
    tout     = 1'b0;
    ph       = phase_q;
    if (item_i.opcode == OP_TICK) begin
      if (since_q != SinceMax) begin
        since_d = since_q + 1'b1;
      end
    end else begin
      // abandon a stale partial frame, then treat this byte as a header candidate
      if (in_frame && (since_q > cfg_i.timeout_ms)) begin
        ph   = PH_HEADER;
        tout = 1'b1;
      end
      unique case (ph)
        PH_MODE: begin
          mode_d  = item_i.rx_byte;
          sum_d   = sum_q + item_i.rx_byte;
          phase_d = PH_LEFT;
        end
        PH_LEFT: begin
          held_l_d = item_i.rx_byte;
          sum_d    = sum_q + item_i.rx_byte;
          phase_d  = PH_RIGHT;
        end
        PH_RIGHT: begin
          held_r_d = item_i.rx_byte;
          sum_d    = sum_q + item_i.rx_byte;
          phase_d  = PH_SUM;
        end
        PH_SUM: begin
          if (item_i.rx_byte == sum_q) begin
            phase_d = PH_END;
          end else begin
            phase_d = PH_HEADER;
            status  = ST_BAD_SUM;
          end
        end
        PH_END: begin
          phase_d = PH_HEADER;
          if (item_i.rx_byte != cfg_i.end_byte) begin
            status = ST_BAD_END;
          end else if (mode_q == cfg_i.remote_mode_code) begin
            app_l_d = held_l_q;
            app_r_d = held_r_q;
            warn_d  = ((held_l_q == '0) && (held_r_q == '0)) ? WARN_STOP : WARN_APPLIED;
            status  = ST_APPLIED;
          end else begin
            status = ST_NOT_REMOTE;
          end
        end
        default: begin
          if (item_i.rx_byte == cfg_i.header_byte) begin
            sum_d   = '0;
            since_d = '0;
            phase_d = PH_MODE;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    result_o.left_cmd      = app_l_d;
    result_o.right_cmd     = app_r_d;
    result_o.warning_level = warn_d;
    result_o.control_mode  = mode_d;
    result_o.frame_status  = status;
    result_o.timed_out     = tout;
  end

`ifndef SYNTHESIS
  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.opcode == OP_TICK) |-> (status == ST_NONE && !tout))
    else $error("tick produced a frame status or timeout");

  a_since_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.opcode == OP_TICK && since_q == SinceMax) |=> (since_q == SinceMax))
    else $error("elapsed counter wrapped");

  a_apply_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && status == ST_APPLIED) |=> (warn_q != WARN_NONE))
    else $error("applied frame left warning at none");

  a_timeout_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && tout) |=> (phase_q == PH_HEADER || phase_q == PH_MODE))
    else $error("timeout did not restart the parse");
`endif

endmodule

`default_nettype wire

// ===== rtl/dcfr_out_buf.sv =====
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module dcfr_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dcfr_pkg::result_t data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_ready_i,
  output dcfr_pkg::result_t      data_o
);

  import dcfr_pkg::*;

  result_t main_q, skid_q;
  logic    main_v_q, skid_v_q;
  logic    pop;

  assign pop     = main_v_q && pop_ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held with empty result register");

  a_skid_promote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && pop) |=> (main_v_q && !skid_v_q))
    else $error("skid entry not promoted on pop");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !pop) |=> skid_v_q)
    else $error("full buffer lost an entry");
`endif

endmodule

`default_nettype wire

// ===== rtl/drive_command_frame_receiver.sv =====
// Top level: configuration registers, frame parser and output buffer.
//
//  channel   direction  payload (low bit first)
//  s_axis    in         tdata: rx_byte[7:0]; tuser: opcode
//  m_axis    out        tdata: left, right, warning, mode, status, timed_out
//  cfg       in         cfg_index_i selects register, cfg_data_i value
//
//  One item per cycle while s_axis_tready_o is high; the combinational parser
//  result for each transaction is registered in the output buffer.
//  Reset clears the parse state, applied speeds, warning and mode to their defaults.
//  A two-entry output buffer keeps input flowing for one more result during an output stall;
//  s_axis_tready_o drops only when both entries hold results.
`default_nettype none

module drive_command_frame_receiver (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [dcfr_pkg::ByteW-1:0]   s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic                         s_axis_tuser_i,   // [0] opcode
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [7:0] left_cmd, [15:8] right_cmd, [17:16] warning_level,
  // [25:18] control_mode, [28:26] frame_status, [29] timed_out, [31:30] zero
  output logic [dcfr_pkg::OutDataW-1:0]     m_axis_tdata_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [dcfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dcfr_pkg::CfgDataW-1:0] cfg_data_i
);

  import dcfr_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  result_t res, out_res;
  logic    accept;
  logic    buf_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte      <= HeaderReset;
      cfg_q.end_byte         <= EndReset;
      cfg_q.timeout_ms       <= TimeoutReset;
      cfg_q.remote_mode_code <= RemoteReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER:  cfg_q.header_byte      <= cfg_data_i[ByteW-1:0];
        CFG_END:     cfg_q.end_byte         <= cfg_data_i[ByteW-1:0];
        CFG_TIMEOUT: cfg_q.timeout_ms       <= cfg_data_i[TimeW-1:0];
        CFG_REMOTE:  cfg_q.remote_mode_code <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = buf_ready;
  assign accept          = s_axis_tvalid_i && buf_ready;
  assign item.opcode     = opcode_e'(s_axis_tuser_i);
  assign item.rx_byte    = s_axis_tdata_i;

  dcfr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (res)
  );

  dcfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {2'b00, out_res.timed_out, out_res.frame_status,
                           out_res.control_mode, out_res.warning_level,
                           out_res.right_cmd, out_res.left_cmd};

endmodule

`default_nettype wire

// ===== tb/sv/tb_drive_command_frame_receiver.sv =====
// Self-checking testbench for the drive command frame receiver: frame parsing, sums, timeouts.
`timescale 1ns / 100ps

module tb_drive_command_frame_receiver;
  import dcfr_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int PhaseItems = 226;
  localparam int ReportCap  = 100;

  // Tracks parser state and holds the results the block owes, oldest first.
  class cmd_frame_scoreboard;
    cfg_t                    cfg;
    phase_e                  phase;
    logic [ByteW-1:0]        sum;
    logic [ByteW-1:0]        held_l;
    logic [ByteW-1:0]        held_r;
    logic [ByteW-1:0]        mode;
    logic signed [ByteW-1:0] app_l;
    logic signed [ByteW-1:0] app_r;
    warn_e                   warn;
    logic [TimeW-1:0]        since;
    result_t                 owed[$];
    int                      failures;

    function new();
      cfg.header_byte      = HeaderReset;
      cfg.end_byte         = EndReset;
      cfg.timeout_ms       = TimeoutReset;
      cfg.remote_mode_code = RemoteReset;
      phase    = PH_HEADER;
      sum      = '0;
      held_l   = '0;
      held_r   = '0;
      mode     = ModeReset;
      app_l    = '0;
      app_r    = '0;
      warn     = WARN_NONE;
      since    = '0;
      failures = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_HEADER:  cfg.header_byte = val[ByteW-1:0];
        CFG_END:     cfg.end_byte = val[ByteW-1:0];
        CFG_TIMEOUT: cfg.timeout_ms = val[TimeW-1:0];
        default:     cfg.remote_mode_code = val[ByteW-1:0];
      endcase
    endfunction

    function void note_item(opcode_e op, logic [ByteW-1:0] b);
      result_t r;
      status_e st;
      logic    tout;
      st   = ST_NONE;
      tout = 1'b0;
      if (op == OP_TICK) begin
        if (since != SinceMax) since = since + 1'b1;
      end else begin
        // Abandon a stale partial frame, then treat the byte as a possible header.
        if (phase != PH_HEADER && since > cfg.timeout_ms) begin
          phase = PH_HEADER;
          tout  = 1'b1;
        end
        case (phase)
          PH_HEADER: begin
            if (b == cfg.header_byte) begin
              sum   = '0;
              since = '0;
              phase = PH_MODE;
            end
          end
          PH_MODE: begin
            mode  = b;
            sum   = sum + b;
            phase = PH_LEFT;
          end
          PH_LEFT: begin
            held_l = b;
            sum    = sum + b;
            phase  = PH_RIGHT;
          end
          PH_RIGHT: begin
            held_r = b;
            sum    = sum + b;
            phase  = PH_SUM;
          end
          PH_SUM: begin
            if (b == sum) begin
              phase = PH_END;
            end else begin
              phase = PH_HEADER;
              st    = ST_BAD_SUM;
            end
          end
          default: begin
            phase = PH_HEADER;
            if (b != cfg.end_byte) begin
              st = ST_BAD_END;
            end else if (mode == cfg.remote_mode_code) begin
              app_l = held_l;
              app_r = held_r;
              warn  = (held_l == '0 && held_r == '0) ? WARN_STOP : WARN_APPLIED;
              st    = ST_APPLIED;
            end else begin
              st = ST_NOT_REMOTE;
            end
          end
        endcase
      end
      r.left_cmd      = app_l;
      r.right_cmd     = app_r;
      r.warning_level = warn;
      r.control_mode  = mode;
      r.frame_status  = st;
      r.timed_out     = tout;
      owed.push_back(r);
    endfunction

    function void report(string field, int want, int got);
      failures++;
      if (failures <= ReportCap) $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[$bits(result_t)-1:0]);
      if (owed.size() == 0) begin
        failures++;
        if (failures <= ReportCap) $error("result with no transaction pending: %h", data);
        return;
      end
      want = owed.pop_front();
      if (got.left_cmd !== want.left_cmd)
        report("left_cmd", want.left_cmd, got.left_cmd);
      if (got.right_cmd !== want.right_cmd)
        report("right_cmd", want.right_cmd, got.right_cmd);
      if (got.warning_level !== want.warning_level)
        report("warning_level", want.warning_level, got.warning_level);
      if (got.control_mode !== want.control_mode)
        report("control_mode", want.control_mode, got.control_mode);
      if (got.frame_status !== want.frame_status)
        report("frame_status", want.frame_status, got.frame_status);
      if (got.timed_out !== want.timed_out)
        report("timed_out", want.timed_out, got.timed_out);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                s_valid   = 1'b0;
  logic [ByteW-1:0]    s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_ready   = 1'b0;
  logic                cfg_valid = 1'b0;
  cfg_idx_e            cfg_index = CFG_HEADER;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                s_ready;
  logic                m_valid;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_ready;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  cmd_frame_scoreboard scoreboard;

  drive_command_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check each result transaction, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_n && m_valid && m_ready) scoreboard.check_result(m_tdata);
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(opcode_e op, logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    scoreboard.note_item(op, b);
    items_sent++;
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (scoreboard.pending() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    scoreboard.write_reg(idx, val);
  endtask

  // Upper data bits of the byte-wide registers carry junk that must be ignored.
  task automatic apply_settings(logic [ByteW-1:0] hdr, logic [ByteW-1:0] eb,
                                logic [TimeW-1:0] tmo, logic [ByteW-1:0] rem);
    write_reg(CFG_HEADER, {8'($urandom), hdr});
    write_reg(CFG_END, {8'($urandom), eb});
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_REMOTE, {8'($urandom), rem});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(logic [ByteW-1:0] mode, logic [ByteW-1:0] l,
                            logic [ByteW-1:0] r, bit bad_sum, bit bad_end);
    logic [ByteW-1:0] sum;
    sum = mode + l + r;
    send_item(OP_BYTE, scoreboard.cfg.header_byte);
    send_item(OP_BYTE, mode);
    send_item(OP_BYTE, l);
    send_item(OP_BYTE, r);
    if (bad_sum) begin
      send_item(OP_BYTE, sum + 8'd1);
    end else begin
      send_item(OP_BYTE, sum);
      send_item(OP_BYTE, bad_end ? scoreboard.cfg.end_byte ^ 8'h01
                                 : scoreboard.cfg.end_byte);
    end
  endtask

  // Mostly well-formed frames with random content; some corrupt, cut short or noise.
  task automatic random_frame(int tick_max);
    logic [ByteW-1:0] seq[6];
    logic [ByteW-1:0] mode;
    logic [ByteW-1:0] l;
    logic [ByteW-1:0] r;
    int               kind;
    int               n;
    kind = $urandom_range(99);
    mode = ($urandom_range(3) != 0) ? scoreboard.cfg.remote_mode_code : 8'($urandom);
    l    = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
    r    = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
    if ($urandom_range(7) == 0) begin
      l = 8'h00;
      r = 8'h00;
    end
    seq[0] = scoreboard.cfg.header_byte;
    seq[1] = mode;
    seq[2] = l;
    seq[3] = r;
    seq[4] = mode + l + r;
    seq[5] = scoreboard.cfg.end_byte;
    n      = 6;
    if (kind < 10) begin
      seq[4] = seq[4] ^ 8'($urandom_range(1, 255));
    end else if (kind < 20) begin
      seq[5] = seq[5] ^ 8'($urandom_range(1, 255));
    end else if (kind < 28) begin
      n = $urandom_range(1, 5);
    end else if (kind < 36) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) seq[i] = 8'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, tick_max)) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, seq[i]);
    end
  endtask

  initial begin
    logic [ByteW-1:0] hdr;
    logic [ByteW-1:0] eb;
    logic [ByteW-1:0] rem;
    logic [TimeW-1:0] tmo;
    int               tick_max;
    int               start;
    scoreboard = new();
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed frames under reset settings.
    send_item(OP_TICK, 8'hFF);
    send_frame(8'h01, 8'h7F, 8'h80, 1'b0, 1'b0);
    send_frame(8'h01, 8'h00, 8'h00, 1'b0, 1'b0);
    send_frame(8'hFF, 8'h12, 8'h34, 1'b1, 1'b0);
    send_frame(8'hFF, 8'h00, 8'h01, 1'b0, 1'b0);
    send_frame(8'h01, 8'h05, 8'h06, 1'b0, 1'b1);
    send_item(OP_BYTE, 8'h00);
    wait_drained();

    // Timeout: abandoned frame restarts on a fresh header byte.
    apply_settings(8'hAA, 8'h55, 16'd1, 8'h01);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_frame(8'h01, 8'h02, 8'h03, 1'b0, 1'b0);
    wait_drained();
    apply_settings(8'hAA, 8'h55, 16'd0, 8'h01);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h01);
    wait_drained();

    // Top timeout value: a partial frame does not time out.
    apply_settings(8'hAA, 8'h55, 16'hFFFF, 8'h01);
    send_item(OP_BYTE, 8'hAA);
    repeat (8) send_item(OP_TICK, 8'($urandom));
    send_item(OP_BYTE, 8'h01);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        hdr = 8'h00; eb = 8'h00; tmo = 16'd1; rem = 8'h00;
      end else if (p == 1) begin
        hdr = 8'hFF; eb = 8'hFF; tmo = 16'hFFFE; rem = 8'hFF;
      end else begin
        hdr = 8'($urandom);
        eb  = 8'($urandom);
        rem = 8'($urandom);
        tmo = $urandom_range(1) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(1, 65534));
      end
      apply_settings(hdr, eb, tmo, rem);
      tick_max = (tmo < 16'd8) ? int'(tmo) + 2 : 3;
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      start = items_sent;
      while (items_sent - start < PhaseItems) random_frame(tick_max);
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (4) @(posedge clk_i);
    if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dcfr_pkg.sv
rtl/dcfr_parser.sv
rtl/dcfr_out_buf.sv
rtl/drive_command_frame_receiver.sv
tb/sv/tb_drive_command_frame_receiver.sv
